// ----- design/dstq_pkg.sv -----
// ----------------------------------------------------------------------------
// dstq_pkg: shared types and constants of the deadline sorted timer queue
// Opcodes, result codes, controller states and the command and status
// bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package dstq_pkg;

   // Field widths of the request and result items
   localparam int OP_W      = 2;
   localparam int TAG_W     = 16;
   localparam int TIMEOUT_W = 32;
   localparam int HANDLE_W  = 4;
   localparam int CODE_W    = 3;
   localparam int SLOT_W    = 4;

   // Request and result bus widths
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 24;

   // Most expirations reported for one tick
   localparam int MAX_RESULTS = 16;
   localparam int COUNT_W     = $clog2(MAX_RESULTS);

   // Request opcodes
   localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

   typedef enum logic [CODE_W-1:0] {
      RSP_ADDED        = 3'd0,
      RSP_FULL         = 3'd1,
      RSP_ZERO_TIMEOUT = 3'd2,
      RSP_DELETED      = 3'd3,
      RSP_NOT_FOUND    = 3'd4,
      RSP_EXPIRED      = 3'd5,
      RSP_NOTHING_DUE  = 3'd6
   } rsp_code_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ADD,
      S_DELETE,
      S_EXPIRE
   } fsm_state_type;

   // Change applied to the sorted cell chain
   typedef enum logic [1:0] {
      ACT_NONE,
      ACT_INSERT,
      ACT_REMOVE,
      ACT_POP
   } chain_act_type;

   // Source of the slot and tag fields of a result
   typedef enum logic [1:0] {
      SEL_ZERO,
      SEL_FREE,
      SEL_HANDLE,
      SEL_HEAD
   } rsp_sel_type;

   typedef struct packed {
      logic          load;
      logic          tick;
      chain_act_type act;
      logic          emit;
      rsp_code_type  code;
      rsp_sel_type   sel;
      logic          last;
   } dstq_cmd_type;

   typedef struct packed {
      logic out_free;
      logic zero_timeout;
      logic full;
      logic found;
      logic head_due;
      logic next_due;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- design/dstq_ctrl.sv -----
// ----------------------------------------------------------------------------
// dstq_ctrl: sequencing controller of the timer queue
// Takes one request at a time, decides the outcome from datapath status and
// issues one chain update and one result per cycle while the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module dstq_ctrl
   import dstq_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   input  wire logic [OP_W-1:0] req_op,
   input  wire dp_status_type status,
   output dstq_cmd_type       cmd
);

   fsm_state_type        state_ff;
   fsm_state_type        state_in;
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   count_in;
   logic                 expire_last;

   // Stop after this expiration when the next head is not due or the cap is hit
   assign expire_last = !(status.next_due && (count_ff != COUNT_W'(MAX_RESULTS - 1)));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               unique case (req_op)
                  OP_TICK:   state_in = S_EXPIRE;
                  OP_ADD:    state_in = S_ADD;
                  OP_DELETE: state_in = S_DELETE;
                  default:   state_in = S_IDLE;
               endcase
            end
         end
         S_ADD, S_DELETE: begin
            if (status.out_free) state_in = S_IDLE;
         end
         S_EXPIRE: begin
            if (status.out_free && (!status.head_due || expire_last)) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (state_ff == S_IDLE) begin
         count_in = '0;
      end else if (state_ff == S_EXPIRE && status.out_free && status.head_due) begin
         count_in = count_ff + COUNT_W'(1);
      end
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
            cmd.tick   = req_tvalid && (req_op == OP_TICK);
         end
         S_ADD: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.last = 1'b1;
               if (status.zero_timeout) begin
                  cmd.code = RSP_ZERO_TIMEOUT;
               end else if (status.full) begin
                  cmd.code = RSP_FULL;
               end else begin
                  cmd.act  = ACT_INSERT;
                  cmd.code = RSP_ADDED;
                  cmd.sel  = SEL_FREE;
               end
            end
         end
         S_DELETE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               cmd.last = 1'b1;
               cmd.sel  = SEL_HANDLE;
               if (status.found) begin
                  cmd.act  = ACT_REMOVE;
                  cmd.code = RSP_DELETED;
               end else begin
                  cmd.code = RSP_NOT_FOUND;
               end
            end
         end
         S_EXPIRE: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.head_due) begin
                  cmd.act  = ACT_POP;
                  cmd.code = RSP_EXPIRED;
                  cmd.sel  = SEL_HEAD;
                  cmd.last = expire_last;
               end else begin
                  cmd.code = RSP_NOTHING_DUE;
                  cmd.last = 1'b1;
               end
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- design/dstq_datapath.sv -----
// ----------------------------------------------------------------------------
// dstq_datapath: sorted cell chain, slot map, tick counter and result register
// Each cell compares its deadline with the new one, so an insert, a removal
// or a pop of the head updates every cell of the chain at once.
// ----------------------------------------------------------------------------
`default_nettype none

module dstq_datapath
   import dstq_pkg::*;
#(
   parameter int NUM_TIMERS = 16
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dstq_cmd_type         cmd,
   output dp_status_type             status,
   input  wire logic [TAG_W-1:0]     req_tag,
   input  wire logic [TIMEOUT_W-1:0] req_timeout,
   input  wire logic [HANDLE_W-1:0]  req_handle,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output rsp_code_type              rsp_code,
   output logic [SLOT_W-1:0]         rsp_slot,
   output logic [TAG_W-1:0]          rsp_tag,
   output logic                      rsp_last
);

   localparam int SW = $clog2(NUM_TIMERS);
   localparam int CW = (SW > SLOT_W) ? SW : SLOT_W;

   // Request held for the work cycle
   logic [TIMEOUT_W-1:0] tick_ff;
   logic [TIMEOUT_W-1:0] deadline_ff;
   logic [TAG_W-1:0]     tag_ff;
   logic [HANDLE_W-1:0]  handle_ff;
   logic                 zero_ff;

   // Cell chain, earliest deadline in cell 0
   logic                 valid_ff [NUM_TIMERS];
   logic                 valid_in [NUM_TIMERS];
   logic [TIMEOUT_W-1:0] dl_ff    [NUM_TIMERS];
   logic [TIMEOUT_W-1:0] dl_in    [NUM_TIMERS];
   logic [TAG_W-1:0]     ctag_ff  [NUM_TIMERS];
   logic [TAG_W-1:0]     ctag_in  [NUM_TIMERS];
   logic [SW-1:0]        cslot_ff [NUM_TIMERS];
   logic [SW-1:0]        cslot_in [NUM_TIMERS];

   // Neighbor views of each cell
   logic                 prev_ahead [NUM_TIMERS];
   logic                 prev_valid [NUM_TIMERS];
   logic [TIMEOUT_W-1:0] prev_dl    [NUM_TIMERS];
   logic [TAG_W-1:0]     prev_tag   [NUM_TIMERS];
   logic [SW-1:0]        prev_slot  [NUM_TIMERS];
   logic                 next_valid [NUM_TIMERS];
   logic [TIMEOUT_W-1:0] next_dl    [NUM_TIMERS];
   logic [TAG_W-1:0]     next_tag   [NUM_TIMERS];
   logic [SW-1:0]        next_slot  [NUM_TIMERS];

   logic [NUM_TIMERS-1:0] ahead;
   logic [NUM_TIMERS-1:0] match;
   logic [NUM_TIMERS-1:0] shift_mask;
   logic [NUM_TIMERS-1:0] busy_ff;
   logic [NUM_TIMERS-1:0] busy_in;
   logic [SW-1:0]         free_slot;
   logic [SW-1:0]         clear_slot;
   logic [CW-1:0]         handle_ext;
   logic [CW-1:0]         free_ext;
   logic [CW-1:0]         head_ext;

   logic                  rsp_valid_ff;
   rsp_code_type          rsp_code_ff;
   logic [SLOT_W-1:0]     rsp_slot_ff;
   logic [TAG_W-1:0]      rsp_tag_ff;
   logic                  rsp_last_ff;

   assign handle_ext = CW'(handle_ff);
   assign free_ext   = CW'(free_slot);
   assign head_ext   = CW'(cslot_ff[0]);

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
      end else if (cmd.tick) begin
         tick_ff <= tick_ff + TIMEOUT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         deadline_ff <= tick_ff + req_timeout;
         tag_ff      <= req_tag;
         handle_ff   <= req_handle;
         zero_ff     <= (req_timeout == '0);
      end
   end

   genvar g;
   generate
      for (g = 0; g < NUM_TIMERS; g++) begin : gen_cell
         assign ahead[g] = valid_ff[g] && (dl_ff[g] < deadline_ff);
         assign match[g] = valid_ff[g] && (CW'(cslot_ff[g]) == handle_ext);
         // Cell g shifts left on a pop, or on removal when the match is at or below it
         assign shift_mask[g] = (cmd.act == ACT_POP) || (|match[g:0]);
         if (g == 0) begin : gen_first
            assign prev_ahead[g] = 1'b1;
            assign prev_valid[g] = 1'b1;
            assign prev_dl[g]    = deadline_ff;
            assign prev_tag[g]   = tag_ff;
            assign prev_slot[g]  = free_slot;
         end else begin : gen_inner
            assign prev_ahead[g] = ahead[g-1];
            assign prev_valid[g] = valid_ff[g-1];
            assign prev_dl[g]    = dl_ff[g-1];
            assign prev_tag[g]   = ctag_ff[g-1];
            assign prev_slot[g]  = cslot_ff[g-1];
         end
         if (g == NUM_TIMERS - 1) begin : gen_last
            assign next_valid[g] = 1'b0;
            assign next_dl[g]    = dl_ff[g];
            assign next_tag[g]   = ctag_ff[g];
            assign next_slot[g]  = cslot_ff[g];
         end else begin : gen_upper
            assign next_valid[g] = valid_ff[g+1];
            assign next_dl[g]    = dl_ff[g+1];
            assign next_tag[g]   = ctag_ff[g+1];
            assign next_slot[g]  = cslot_ff[g+1];
         end
      end
   endgenerate

   always_comb begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
         valid_in[i] = valid_ff[i];
         dl_in[i]    = dl_ff[i];
         ctag_in[i]  = ctag_ff[i];
         cslot_in[i] = cslot_ff[i];
         case (cmd.act)
            ACT_INSERT: begin
               // Cells behind the insert point move back by one
               if (!ahead[i]) begin
                  valid_in[i] = valid_ff[i] || prev_valid[i];
                  if (prev_ahead[i]) begin
                     dl_in[i]    = deadline_ff;
                     ctag_in[i]  = tag_ff;
                     cslot_in[i] = free_slot;
                  end else begin
                     dl_in[i]    = prev_dl[i];
                     ctag_in[i]  = prev_tag[i];
                     cslot_in[i] = prev_slot[i];
                  end
               end
            end
            ACT_REMOVE, ACT_POP: begin
               if (shift_mask[i]) begin
                  valid_in[i] = next_valid[i];
                  dl_in[i]    = next_dl[i];
                  ctag_in[i]  = next_tag[i];
                  cslot_in[i] = next_slot[i];
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TIMERS; i++) valid_ff[i] <= 1'b0;
      end else begin
         for (int i = 0; i < NUM_TIMERS; i++) valid_ff[i] <= valid_in[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_TIMERS; i++) begin
         dl_ff[i]    <= dl_in[i];
         ctag_ff[i]  <= ctag_in[i];
         cslot_ff[i] <= cslot_in[i];
      end
   end

   // Lowest free slot
   always_comb begin
      free_slot = '0;
      for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) free_slot = SW'(i);
      end
   end

   assign clear_slot = (cmd.act == ACT_POP) ? cslot_ff[0] : handle_ext[SW-1:0];

   always_comb begin
      busy_in = busy_ff;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         case (cmd.act)
            ACT_INSERT: if (free_slot == SW'(i)) busy_in[i] = 1'b1;
            ACT_REMOVE, ACT_POP: if (clear_slot == SW'(i)) busy_in[i] = 1'b0;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   assign status.out_free     = !rsp_valid_ff || rsp_ready;
   assign status.zero_timeout = zero_ff;
   assign status.full         = &busy_ff;
   assign status.found        = |match;
   assign status.head_due     = valid_ff[0] && (dl_ff[0] <= tick_ff);
   assign status.next_due     = valid_ff[1] && (dl_ff[1] <= tick_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_code_ff <= cmd.code;
         rsp_last_ff <= cmd.last;
         case (cmd.sel)
            SEL_FREE: begin
               rsp_slot_ff <= free_ext[SLOT_W-1:0];
               rsp_tag_ff  <= tag_ff;
            end
            SEL_HANDLE: begin
               rsp_slot_ff <= handle_ff;
               rsp_tag_ff  <= '0;
            end
            SEL_HEAD: begin
               rsp_slot_ff <= head_ext[SLOT_W-1:0];
               rsp_tag_ff  <= ctag_ff[0];
            end
            default: begin
               rsp_slot_ff <= '0;
               rsp_tag_ff  <= '0;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_code  = rsp_code_ff;
   assign rsp_slot  = rsp_slot_ff;
   assign rsp_tag   = rsp_tag_ff;
   assign rsp_last  = rsp_last_ff;

endmodule

`default_nettype wire

// ----- design/deadline_sorted_timer_queue.sv -----
// ----------------------------------------------------------------------------
// deadline_sorted_timer_queue: one-shot timer queue sorted by deadline
// Holds up to NUM_TIMERS timers in a chain of cells ordered by absolute
// deadline and advances a 32-bit tick count on every tick request.
// ----------------------------------------------------------------------------
// The queue takes one request at a time on the req_ stream and answers on the
// rsp_ stream. An add or a delete transfers its request; then, once the output
// register is free, every cell of the sorted chain updates at once and the single
// result is written to the output register. A tick answers with one result per
// timer that expires (at most 16): the count advances as the request transfers,
// then the head cell is checked and popped once per cycle while the output
// register is free, one result per pop, with tlast on the final one. A tick with
// nothing due answers once with the nothing-due code. The result register lets
// the next request transfer while the last result still waits; backpressure on
// rsp_ holds back any further result until the register is free. Adds take the
// lowest free slot, go ahead of timers with an equal deadline, and deadlines wrap
// modulo 2^32. Opcode 3 transfers and is dropped without a result. No clearing
// pass follows reset: cell and slot valid bits clear at once.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_sorted_timer_queue
   import dstq_pkg::*;
#(
   parameter int NUM_TIMERS = 16
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // op [1:0], tag [17:2], timeout [49:18], handle [53:50], zero [55:54]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // Result stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // status [2:0], slot [6:3], expired_tag [22:7], zero [23]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   output logic                       rsp_tlast
);

   logic [OP_W-1:0]      req_op;
   logic [TAG_W-1:0]     req_tag;
   logic [TIMEOUT_W-1:0] req_timeout;
   logic [HANDLE_W-1:0]  req_handle;

   dstq_cmd_type         cmd;
   dp_status_type        status;

   rsp_code_type         rsp_code;
   logic [SLOT_W-1:0]    rsp_slot;
   logic [TAG_W-1:0]     rsp_tag;

   // Unpack the request fields, lowest field first
   assign req_op      = req_tdata[1:0];
   assign req_tag     = req_tdata[17:2];
   assign req_timeout = req_tdata[49:18];
   assign req_handle  = req_tdata[53:50];

   // Sequence one request at a time and drive the datapath
   dstq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_op),
      .status     (status),
      .cmd        (cmd)
   );

   // Sorted cells, slot map, tick count and result register
   dstq_datapath #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_tag     (req_tag),
      .req_timeout (req_timeout),
      .req_handle  (req_handle),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_code    (rsp_code),
      .rsp_slot    (rsp_slot),
      .rsp_tag     (rsp_tag),
      .rsp_last    (rsp_tlast)
   );

   // Pack the result fields, lowest field first, pad to whole bytes
   assign rsp_tdata = {1'b0, rsp_tag, rsp_slot, rsp_code};

`ifndef SYNTHESIS
   // Never overwrite a result that is still waiting for its transfer
   assert_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("result written while output register still held a result");

   // Insert only when a slot is free and the timeout is nonzero
   assert_insert_ok: assert property (@(posedge clock) disable iff (reset)
      (cmd.act == ACT_INSERT) |-> (!status.full && !status.zero_timeout))
      else $error("insert issued on a full queue or a zero timeout");

   // A request that owes a result blocks the next one in the cycle after it
   assert_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready &&
       (req_op == OP_TICK || req_op == OP_ADD || req_op == OP_DELETE))
      |=> !req_tready)
      else $error("request accepted while previous one still owes a result");
`endif

endmodule

`default_nettype wire

// ----- verif/deadline_sorted_timer_queue_test.sv -----
// ----------------------------------------------------------------------------
// deadline_sorted_timer_queue_test: self-checking bench of the timer queue
// Feeds tick, add, delete and unused-opcode requests through the req_ stream
// and predicts every result. The prediction keeps its own sorted timer chain
// and slot map. Each transfer on the rsp_ stream is checked field by field
// against the oldest predicted result. The run covers several idling
// patterns, a long result backpressure and a full drain between phases.
// ----------------------------------------------------------------------------

module deadline_sorted_timer_queue_test
   import dstq_pkg::*;
();

   localparam int NUM_TIMERS  = 16;
   localparam int HOLD_CYCLES = 300;      // long rsp_ backpressure
   localparam int END_SETTLE  = 40;       // quiet cycles after the last result
   localparam int RUN_LIMIT   = 300000;   // cycles before the run is declared hung
   localparam int PHASE_ITEMS = 76;       // random requests per idling phase

   // Opcode 3 has no name in the package; the block drops it
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [OP_W-1:0]      op;
      logic [TAG_W-1:0]     tag;
      logic [TIMEOUT_W-1:0] timeout;
      logic [HANDLE_W-1:0]  handle;
   } timer_request_type;

   typedef struct {
      rsp_code_type       code;
      logic [SLOT_W-1:0]  slot;
      logic [TAG_W-1:0]   tag;
      logic               last;
   } timer_result_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;

   // Stimulus and checking bookkeeping
   timer_request_type pending_requests [$];
   timer_result_type  expected_results [$];
   timer_request_type offered_request;
   int             send_idle_pct  = 0;
   int             recv_stall_pct = 0;
   logic           hold_armed     = 1'b0;
   logic           rsp_hold       = 1'b0;
   int             error_count    = 0;
   int             cycle_count    = 0;

   // Predicted queue state: sorted chain of live timers plus the slot map
   logic [TIMEOUT_W-1:0] tick_now;
   logic [TIMEOUT_W-1:0] chain_deadline [NUM_TIMERS];
   logic [TAG_W-1:0]     chain_tag      [NUM_TIMERS];
   logic [SLOT_W-1:0]    chain_slot     [NUM_TIMERS];
   int                   chain_depth;
   logic                 slot_taken     [NUM_TIMERS];

   deadline_sorted_timer_queue #(
      .NUM_TIMERS (NUM_TIMERS)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $time, msg);
   endtask

   task automatic push_result(input rsp_code_type code, input logic [SLOT_W-1:0] slot,
                              input logic [TAG_W-1:0] tag, input logic last);
      timer_result_type r;
      r.code = code;
      r.slot = slot;
      r.tag  = tag;
      r.last = last;
      expected_results.push_back(r);
   endtask

   // Close the gap left by a timer leaving the chain
   task automatic drop_chain_entry(input int pos);
      for (int i = pos; i + 1 < chain_depth; i++) begin
         chain_deadline[i] = chain_deadline[i + 1];
         chain_tag[i]      = chain_tag[i + 1];
         chain_slot[i]     = chain_slot[i + 1];
      end
      if (chain_depth > 0) chain_depth--;
   endtask

   task automatic apply_timer_request(input timer_request_type r);
      int                   due;
      int                   free_slot;
      int                   pos;
      logic                 found;
      logic [TIMEOUT_W-1:0] deadline;
      due = 0;
      free_slot = 0;
      pos = 0;
      found = 1'b0;
      case (r.op)
         OP_TICK: begin
            tick_now = tick_now + 1;
            // Chain is sorted, so the due timers form a prefix
            while (due < MAX_RESULTS && due < chain_depth && chain_deadline[due] <= tick_now)
               due++;
            if (due == 0) begin
               push_result(RSP_NOTHING_DUE, '0, '0, 1'b1);
            end else begin
               for (int k = 0; k < due; k++) begin
                  push_result(RSP_EXPIRED, chain_slot[0], chain_tag[0], k == due - 1);
                  slot_taken[chain_slot[0]] = 1'b0;
                  drop_chain_entry(0);
               end
            end
         end
         OP_ADD: begin
            while (free_slot < NUM_TIMERS && slot_taken[free_slot]) free_slot++;
            if (r.timeout == 0) begin
               push_result(RSP_ZERO_TIMEOUT, '0, '0, 1'b1);
            end else if (free_slot >= NUM_TIMERS || chain_depth >= NUM_TIMERS) begin
               push_result(RSP_FULL, '0, '0, 1'b1);
            end else begin
               deadline = tick_now + r.timeout;
               // Strict compare puts the new timer ahead of equal deadlines
               while (pos < chain_depth && chain_deadline[pos] < deadline) pos++;
               for (int i = chain_depth; i > pos; i--) begin
                  chain_deadline[i] = chain_deadline[i - 1];
                  chain_tag[i]      = chain_tag[i - 1];
                  chain_slot[i]     = chain_slot[i - 1];
               end
               chain_deadline[pos] = deadline;
               chain_tag[pos]      = r.tag;
               chain_slot[pos]     = free_slot[SLOT_W-1:0];
               chain_depth++;
               slot_taken[free_slot] = 1'b1;
               push_result(RSP_ADDED, free_slot[SLOT_W-1:0], r.tag, 1'b1);
            end
         end
         OP_DELETE: begin
            if (slot_taken[r.handle]) begin
               for (int i = 0; i < chain_depth; i++) begin
                  if (!found && chain_slot[i] == r.handle) begin
                     drop_chain_entry(i);
                     found = 1'b1;
                  end
               end
            end
            if (found) begin
               slot_taken[r.handle] = 1'b0;
               push_result(RSP_DELETED, r.handle, '0, 1'b1);
            end else begin
               push_result(RSP_NOT_FOUND, r.handle, '0, 1'b1);
            end
         end
         default: ;   // unused opcode: no result, no state change
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Request driver: predict each accepted transfer, then offer the next item
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else begin
         if (req_tvalid && req_tready) apply_timer_request(offered_request);
         // Advance only once the current offer has transferred
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               offered_request = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {2'b00, offered_request.handle, offered_request.timeout,
                              offered_request.tag, offered_request.op};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Result side: random stalls, plus a long hold when the stimulus asks
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset)
         rsp_tready <= 1'b0;
      else if (rsp_hold)
         rsp_tready <= 1'b0;
      else
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Hold off rsp_ for a fixed stretch so the result register fills and
   // req_tready drops while the driver keeps offering
   initial begin
      while (!hold_armed) @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   // Compare every result transfer with the oldest prediction
   always @(posedge clock) begin : check_results
      timer_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected: status %0d slot %0d tag %h",
                                      rsp_tdata[2:0], rsp_tdata[6:3], rsp_tdata[22:7]));
         end else begin
            want = expected_results.pop_front();
            if (rsp_tdata[2:0] !== want.code)
               report_mismatch($sformatf("status %0d, expected %0d (%s)",
                                         rsp_tdata[2:0], want.code, want.code.name()));
            if (rsp_tdata[6:3] !== want.slot)
               report_mismatch($sformatf("slot %0d, expected %0d", rsp_tdata[6:3], want.slot));
            if (rsp_tdata[22:7] !== want.tag)
               report_mismatch($sformatf("tag %h, expected %h", rsp_tdata[22:7], want.tag));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("tlast %b, expected %b", rsp_tlast, want.last));
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   task automatic queue_request(input logic [OP_W-1:0] op, input logic [TAG_W-1:0] tag,
                                input logic [TIMEOUT_W-1:0] timeout,
                                input logic [HANDLE_W-1:0] handle);
      timer_request_type r;
      r.op      = op;
      r.tag     = tag;
      r.timeout = timeout;
      r.handle  = handle;
      pending_requests.push_back(r);
   endtask

   // Mostly short timeouts so timers expire; some long, wrapping and zero
   function automatic logic [TIMEOUT_W-1:0] pick_timeout();
      int roll;
      roll = $urandom_range(99);
      if (roll < 5)  return '0;
      if (roll < 60) return $urandom_range(8, 1);
      if (roll < 75) return $urandom_range(64, 1);
      if (roll < 85) return $urandom;
      if (roll < 93) return 32'hFFFF_FFFF - $urandom_range(600, 0);
      return 32'hFFFF_FFFF;
   endfunction

   // Hold the sender until every predicted result has transferred
   task automatic wait_until_drained();
      while (!(pending_requests.size() == 0 && !req_tvalid && expected_results.size() == 0))
         @(negedge clock);
   endtask

   task automatic queue_random_phase(input int target);
      int issued;
      int burst;
      int shared;
      int roll;
      issued = 0;
      while (issued < target) begin
         if ($urandom_range(99) < 30) begin
            // Burst of adds with close, often equal, deadlines and occasional deletes, then ticks
            burst  = $urandom_range(8, 2);
            shared = $urandom_range(3, 1);
            for (int i = 0; i < burst; i++) begin
               queue_request(OP_ADD, TAG_W'($urandom),
                             TIMEOUT_W'($urandom_range(1) ? shared : $urandom_range(5, 1)),
                             HANDLE_W'($urandom));
               if ($urandom_range(99) < 15)
                  queue_request(OP_DELETE, TAG_W'($urandom), $urandom,
                                HANDLE_W'($urandom_range(15, 0)));
            end
            issued += burst;
            burst = $urandom_range(6, 1);
            repeat (burst)
               queue_request(OP_TICK, TAG_W'($urandom), $urandom, HANDLE_W'($urandom));
            issued += burst;
         end else begin
            roll = $urandom_range(99);
            if (roll < 38)
               queue_request(OP_TICK, TAG_W'($urandom), $urandom, HANDLE_W'($urandom));
            else if (roll < 72)
               queue_request(OP_ADD, TAG_W'($urandom), pick_timeout(), HANDLE_W'($urandom));
            else if (roll < 95)
               queue_request(OP_DELETE, TAG_W'($urandom), $urandom,
                             HANDLE_W'($urandom_range(15, 0)));
            else
               queue_request(OP_UNUSED, TAG_W'($urandom), $urandom, HANDLE_W'($urandom));
            // dropped opcodes do not count toward the phase
            if (roll < 95) issued++;
         end
      end
   endtask

   initial begin
      tick_now    = '0;
      chain_depth = 0;
      for (int i = 0; i < NUM_TIMERS; i++) slot_taken[i] = 1'b0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part, no idling
      queue_request(OP_TICK, '0, '0, '0);                  // empty queue: nothing due
      queue_request(OP_ADD, 16'hFFFF, '0, '0);             // zero timeout rejected
      queue_request(OP_ADD, 16'hFFFF, 32'd1, '0);          // slot 0
      queue_request(OP_ADD, 16'h0000, 32'd1, '0);          // equal deadline, goes first
      queue_request(OP_DELETE, '0, '0, 4'hF);              // handle never used
      queue_request(OP_DELETE, '0, '0, 4'h0);              // live handle
      queue_request(OP_ADD, 16'h1234, 32'hFFFF_FFFF, '0);  // wrapped deadline, due at once
      queue_request(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 4'hF);
      queue_request(OP_TICK, '0, '0, '0);                  // two expire, wrapped one first
      for (int i = 0; i < NUM_TIMERS; i++)
         queue_request(OP_ADD, TAG_W'(16'hA000 + i), 32'd1, '0);   // fill every slot
      queue_request(OP_ADD, 16'h5555, 32'd5, '0);          // store full
      queue_request(OP_ADD, 16'h5555, '0, '0);             // zero timeout wins over full
      queue_request(OP_TICK, '0, '0, '0);                  // all sixteen expire at once
      wait_until_drained();

      // Phase 1: no idling, with the long rsp_ hold-off at its start
      hold_armed = 1'b1;
      queue_random_phase(PHASE_ITEMS);
      wait_until_drained();

      // Phase 2: sender mostly idle
      send_idle_pct  = 80;
      recv_stall_pct = 0;
      queue_random_phase(PHASE_ITEMS);
      wait_until_drained();

      // Phase 3: receiver mostly stalled
      send_idle_pct  = 0;
      recv_stall_pct = 80;
      queue_random_phase(PHASE_ITEMS);
      wait_until_drained();

      // Phase 4: both sides idle now and then
      send_idle_pct  = 24;
      recv_stall_pct = 24;
      queue_random_phase(PHASE_ITEMS);
      wait_until_drained();

      // Let any stray result show up before the verdict
      repeat (END_SETTLE) @(negedge clock);
      if (error_count == 0)
         $display("deadline_sorted_timer_queue_test: clean");
      else
         $display("deadline_sorted_timer_queue_test: errors");
      $finish;
   end

   // Hang guard
   initial begin
      while (cycle_count < RUN_LIMIT) @(posedge clock);
      $display("[%0t] timeout with %0d requests and %0d results outstanding", $time,
               pending_requests.size(), expected_results.size());
      $display("deadline_sorted_timer_queue_test: errors");
      $finish;
   end

endmodule

// ----- sim.f -----
design/dstq_pkg.sv
design/dstq_ctrl.sv
design/dstq_datapath.sv
design/deadline_sorted_timer_queue.sv
verif/deadline_sorted_timer_queue_test.sv
